[rtl/crpu_pkg.sv]
// shared types, constants and codes for the control register pinning unit
`default_nettype none

package crpu_pkg;

    // default counter width
    localparam int COUNTER_WIDTH_DEF = 32;

    // state memory geometry
    localparam int MEM_DEPTH  = 16;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int DATA_W     = 64;
    localparam int MEM_W      = 2 * DATA_W;

    // apb geometry
    localparam int CFG_AW     = 5;

    // exit kinds
    localparam logic KIND_CR = 1'b0;
    localparam logic KIND_DR = 1'b1;

    // control register numbers
    localparam logic [3:0] CR_NUM_CR0 = 4'd0;
    localparam logic [3:0] CR_NUM_CR3 = 4'd3;
    localparam logic [3:0] CR_NUM_CR4 = 4'd4;

    // general register that may not be used (rsp)
    localparam logic [3:0] GPR_RSP = 4'd4;

    // debug register numbers with no storage
    localparam logic [2:0] DR_NUM_DR4 = 3'd4;
    localparam logic [2:0] DR_NUM_DR5 = 3'd5;

    // debug direction
    localparam logic DR_DIR_WRITE = 1'b0;

    // cr0 bits touched by clts and lmsw
    localparam logic [DATA_W-1:0] CR0_PE    = 64'h1;
    localparam logic [DATA_W-1:0] CR0_TS    = 64'h8;
    localparam logic [DATA_W-1:0] LMSW_BITS = 64'hF;

    // state memory map: debug registers sit at their own numbers
    localparam logic [MEM_AW-1:0] ADDR_CR0 = MEM_AW'(4);
    localparam logic [MEM_AW-1:0] ADDR_CR3 = MEM_AW'(5);
    localparam logic [MEM_AW-1:0] ADDR_CR4 = MEM_AW'(8);

    // control register access types
    typedef enum logic [1:0] {
        ACC_WRITE = 2'd0,
        ACC_READ  = 2'd1,
        ACC_CLTS  = 2'd2,
        ACC_LMSW  = 2'd3
    } acc_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CR0_PIN_MASK  = 2'd0,
        CFG_CR0_PIN_VALUE = 2'd1,
        CFG_CR4_PIN_MASK  = 2'd2,
        CFG_CR4_PIN_VALUE = 2'd3
    } cfg_idx_t;

    // pinning policy handed to the datapath
    typedef struct packed {
        logic [DATA_W-1:0] cr0_mask;
        logic [DATA_W-1:0] cr0_value;
        logic [DATA_W-1:0] cr4_mask;
        logic [DATA_W-1:0] cr4_value;
    } pin_cfg_t;

    // state memory write request: upper half shadow, lower half guest value
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [MEM_W-1:0]  data;
    } mem_wr_t;

    // one result beat
    typedef struct packed {
        logic              handled;
        logic              pin_refused;
        logic              gpr_write;
        logic [3:0]        gpr_index;
        logic [DATA_W-1:0] gpr_data;
        logic [DATA_W-1:0] installed_value;
        logic [DATA_W-1:0] shadow_value;
        logic [31:0]       refused_total;
        logic [31:0]       cr3_switch_total;
        logic [31:0]       debug_access_total;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/crpu_if.sv]
// valid/ready channel interfaces for access requests and results
`default_nettype none

interface crpu_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] exit_qualification;
    logic [63:0] gpr_value;

    modport source (output valid, kind, exit_qualification, gpr_value, input ready);
    modport sink   (input valid, kind, exit_qualification, gpr_value, output ready);
endinterface

interface crpu_rsp_if;
    logic        valid;
    logic        ready;
    logic        handled;
    logic        pin_refused;
    logic        gpr_write;
    logic [3:0]  gpr_index;
    logic [63:0] gpr_data;
    logic [63:0] installed_value;
    logic [63:0] shadow_value;
    logic [31:0] refused_total;
    logic [31:0] cr3_switch_total;
    logic [31:0] debug_access_total;

    modport source (
        output valid, handled, pin_refused, gpr_write, gpr_index, gpr_data,
               installed_value, shadow_value, refused_total, cr3_switch_total,
               debug_access_total,
        input  ready
    );
    modport sink (
        input  valid, handled, pin_refused, gpr_write, gpr_index, gpr_data,
               installed_value, shadow_value, refused_total, cr3_switch_total,
               debug_access_total,
        output ready
    );
endinterface

`default_nettype wire

[rtl/control_register_pinning_unit.sv]
// top level of the control register pinning unit
//
//   channel  dir  handshake        carries
//   req      in   valid/ready      kind, exit_qualification, gpr_value
//   rsp      out  valid/ready      handled, pin_refused, gpr_*, values, totals
//   apb      in   psel/penable     pinning masks and values, 64-bit at 8*i
//
// one access per cycle sustained while rsp is not stalled; the accepting edge
// loads stage 1 and the state memory read register, and when the item advances
// it does modify, write-back and the result register, which raises rsp valid.
// same-entry back-to-back accesses are forwarded inside the memory. reset
// clears counters, valid flags and per-entry written flags (unwritten entries
// read as zero), no clearing pass. a stalled rsp holds the item in the read
// stage; req keeps flowing while the result register drains.
`default_nettype none

module control_register_pinning_unit #(
    parameter int COUNTER_WIDTH = crpu_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    crpu_req_if.sink                           req,
    crpu_rsp_if.source                         rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crpu_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [crpu_pkg::DATA_W-1:0]   pwdata,
    output logic      [crpu_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import crpu_pkg::*;

    pin_cfg_t          pin_cfg;
    mem_wr_t           wr;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_W-1:0]  rd_data;

    // pinning policy registers
    crpu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pin_cfg (pin_cfg)
    );

    // guest register state
    crpu_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // access pipeline
    crpu_ctrl #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .pin_cfg (pin_cfg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // an unhandled access never hands data back, installs a value or reports a pin refusal
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.handled) |->
            (!rsp.gpr_write && (rsp.installed_value == '0) && !rsp.pin_refused))
    else $error("refused access carries a side effect");

    // rsp is never the target of read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.gpr_write) |-> (rsp.gpr_index != GPR_RSP))
    else $error("read data routed to rsp");

    // only pinning writes touch the shadow, and they never return data
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.pin_refused) |-> !rsp.gpr_write)
    else $error("pin refusal on a read");

    // memory write only happens when the pipeline advances a handled item
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> rsp.valid)
    else $error("state write without a result");

endmodule

`default_nettype wire

[rtl/crpu_cfg.sv]
// apb register block holding the cr0/cr4 pinning policy
`default_nettype none

module crpu_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crpu_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [crpu_pkg::DATA_W-1:0]   pwdata,
    output logic      [crpu_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output crpu_pkg::pin_cfg_t                 pin_cfg
);
    import crpu_pkg::*;

    pin_cfg_t pin_cfg_reg;
    pin_cfg_t pin_cfg_next;
    cfg_idx_t idx;
    logic     wr_beat;

    assign pready  = 1'b1;
    assign idx     = cfg_idx_t'(paddr[CFG_AW-1:3]);
    assign wr_beat = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        pin_cfg_next = pin_cfg_reg;
        if (wr_beat)
        begin
            unique case (idx)
                CFG_CR0_PIN_MASK:  pin_cfg_next.cr0_mask  = pwdata;
                CFG_CR0_PIN_VALUE: pin_cfg_next.cr0_value = pwdata;
                CFG_CR4_PIN_MASK:  pin_cfg_next.cr4_mask  = pwdata;
                CFG_CR4_PIN_VALUE: pin_cfg_next.cr4_value = pwdata;
                default:           pin_cfg_next = pin_cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            CFG_CR0_PIN_MASK:  prdata = pin_cfg_reg.cr0_mask;
            CFG_CR0_PIN_VALUE: prdata = pin_cfg_reg.cr0_value;
            CFG_CR4_PIN_MASK:  prdata = pin_cfg_reg.cr4_mask;
            CFG_CR4_PIN_VALUE: prdata = pin_cfg_reg.cr4_value;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_cfg_reg <= '0;
        end
        else
        begin
            pin_cfg_reg <= pin_cfg_next;
        end
    end

    assign pin_cfg = pin_cfg_reg;

endmodule

`default_nettype wire

[rtl/crpu_mem.sv]
// register state memory: one write, one registered read, write-first forwarding
`default_nettype none

module crpu_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire crpu_pkg::mem_wr_t            wr,
    input  wire logic                         rd_en,
    input  wire logic [crpu_pkg::MEM_AW-1:0]  rd_addr,
    output logic      [crpu_pkg::MEM_W-1:0]   rd_data
);
    import crpu_pkg::*;

    logic [MEM_W-1:0]     mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [MEM_W-1:0]     rd_data_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // per-entry written flags, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // registered read, same-edge write is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/crpu_ctrl.sv]
// access pipeline: address decode, read-modify-write, counters, result register
`default_nettype none

module crpu_ctrl #(
    parameter int COUNTER_WIDTH = crpu_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    crpu_req_if.sink                          req,
    crpu_rsp_if.source                        rsp,
    input  wire crpu_pkg::pin_cfg_t           pin_cfg,
    output logic                              rd_en,
    output logic      [crpu_pkg::MEM_AW-1:0]  rd_addr,
    input  wire logic [crpu_pkg::MEM_W-1:0]   rd_data,
    output crpu_pkg::mem_wr_t                 wr
);
    import crpu_pkg::*;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    // stage 1 holds the item whose memory word is being read
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_kind_reg;
    logic [31:0]       s1_q_reg;
    logic [DATA_W-1:0] s1_val_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic [COUNTER_WIDTH-1:0] refused_cnt_reg, refused_cnt_next;
    logic [COUNTER_WIDTH-1:0] cr3_cnt_reg, cr3_cnt_next;
    logic [COUNTER_WIDTH-1:0] dbg_cnt_reg, dbg_cnt_next;

    logic              advance;
    logic              accept;
    logic [3:0]        in_num;

    // stage 1 decode
    logic [3:0]        gpr;
    logic [3:0]        cr_num;
    acc_t              acc;
    logic [2:0]        dr_num;
    logic              dr_dir;
    logic [DATA_W-1:0] guest;
    logic [DATA_W-1:0] pin_m;
    logic [DATA_W-1:0] pin_v;
    logic [DATA_W-1:0] pin_req;
    logic [DATA_W-1:0] merged;
    logic              do_pin;
    logic              inc_refused;
    logic              inc_cr3;
    logic              inc_dbg;
    mem_wr_t           wr_c;

    // handshake and pipeline advance
    assign advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign accept  = req.valid && req.ready;
    assign req.ready = !s1_valid_reg || advance;

    // read address from the incoming beat
    assign in_num = req.exit_qualification[3:0];
    always_comb
    begin
        if (req.kind == KIND_DR)
        begin
            rd_addr = MEM_AW'(req.exit_qualification[2:0]);
        end
        else if (in_num == CR_NUM_CR3)
        begin
            rd_addr = ADDR_CR3;
        end
        else
        begin
            rd_addr = ADDR_CR0;
        end
    end
    assign rd_en = accept;

    // stage 1 field split
    assign gpr    = s1_q_reg[11:8];
    assign cr_num = s1_q_reg[3:0];
    assign acc    = acc_t'(s1_q_reg[5:4]);
    assign dr_num = s1_q_reg[2:0];
    assign dr_dir = s1_q_reg[4];
    assign guest  = rd_data[DATA_W-1:0];
    assign pin_m  = (cr_num == CR_NUM_CR0) ? pin_cfg.cr0_mask : pin_cfg.cr4_mask;
    assign pin_v  = ((cr_num == CR_NUM_CR0) ? pin_cfg.cr0_value : pin_cfg.cr4_value) & pin_m;

    // access service, saturating counters and memory write-back
    always_comb
    begin
        out_next         = '0;
        wr_c             = '0;
        do_pin           = 1'b0;
        pin_req          = s1_val_reg;
        merged           = '0;
        inc_refused      = 1'b0;
        inc_cr3          = 1'b0;
        inc_dbg          = 1'b0;
        refused_cnt_next = refused_cnt_reg;
        cr3_cnt_next     = cr3_cnt_reg;
        dbg_cnt_next     = dbg_cnt_reg;
        if (s1_kind_reg == KIND_CR)
        begin
            if (cr_num == CR_NUM_CR3)
            begin
                if (gpr != GPR_RSP)
                begin
                    case (acc)
                        ACC_WRITE:
                        begin
                            inc_cr3                  = 1'b1;
                            wr_c.en                  = 1'b1;
                            wr_c.addr                = ADDR_CR3;
                            wr_c.data                = {{DATA_W{1'b0}}, s1_val_reg};
                            out_next.installed_value = s1_val_reg;
                            out_next.handled         = 1'b1;
                        end
                        ACC_READ:
                        begin
                            out_next.gpr_write = 1'b1;
                            out_next.gpr_index = gpr;
                            out_next.gpr_data  = guest;
                            out_next.handled   = 1'b1;
                        end
                        default:
                        begin
                            out_next.handled = 1'b0;
                        end
                    endcase
                end
            end
            else if ((cr_num == CR_NUM_CR0) || (cr_num == CR_NUM_CR4))
            begin
                if ((cr_num == CR_NUM_CR0) && (acc == ACC_CLTS))
                begin
                    pin_req = guest & ~CR0_TS;
                    do_pin  = 1'b1;
                end
                else if ((cr_num == CR_NUM_CR0) && (acc == ACC_LMSW))
                begin
                    // pe can be set but never cleared
                    pin_req = (guest & ~LMSW_BITS)
                            | ({{(DATA_W-16){1'b0}}, s1_q_reg[31:16]} & LMSW_BITS)
                            | (guest & CR0_PE);
                    do_pin  = 1'b1;
                end
                else if ((acc == ACC_WRITE) && (gpr != GPR_RSP))
                begin
                    pin_req = s1_val_reg;
                    do_pin  = 1'b1;
                end
            end
        end
        else if (gpr != GPR_RSP)
        begin
            inc_dbg = 1'b1;
            if ((dr_num != DR_NUM_DR4) && (dr_num != DR_NUM_DR5))
            begin
                if (dr_dir == DR_DIR_WRITE)
                begin
                    wr_c.en   = 1'b1;
                    wr_c.addr = MEM_AW'(dr_num);
                    wr_c.data = {{DATA_W{1'b0}}, s1_val_reg};
                end
                else
                begin
                    out_next.gpr_write = 1'b1;
                    out_next.gpr_index = gpr;
                    out_next.gpr_data  = guest;
                end
                out_next.handled = 1'b1;
            end
        end

        // pinned write to cr0 or cr4: guest gets merged value, shadow the request
        if (do_pin)
        begin
            merged                   = (pin_req & ~pin_m) | pin_v;
            inc_refused              = ((pin_req & pin_m) != pin_v);
            out_next.pin_refused     = inc_refused;
            wr_c.en                  = 1'b1;
            wr_c.addr                = (cr_num == CR_NUM_CR0) ? ADDR_CR0 : ADDR_CR4;
            wr_c.data                = {pin_req, merged};
            out_next.installed_value = merged;
            out_next.shadow_value    = pin_req;
            out_next.handled         = 1'b1;
        end

        // saturating counters
        if (inc_refused && (refused_cnt_reg != CNT_MAX))
        begin
            refused_cnt_next = refused_cnt_reg + COUNTER_WIDTH'(1);
        end
        if (inc_cr3 && (cr3_cnt_reg != CNT_MAX))
        begin
            cr3_cnt_next = cr3_cnt_reg + COUNTER_WIDTH'(1);
        end
        if (inc_dbg && (dbg_cnt_reg != CNT_MAX))
        begin
            dbg_cnt_next = dbg_cnt_reg + COUNTER_WIDTH'(1);
        end

        out_next.refused_total      = 32'(refused_cnt_next);
        out_next.cr3_switch_total   = 32'(cr3_cnt_next);
        out_next.debug_access_total = 32'(dbg_cnt_next);
    end

    assign wr = '{en: wr_c.en && advance, addr: wr_c.addr, data: wr_c.data};

    // valid flags
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            refused_cnt_reg <= '0;
            cr3_cnt_reg     <= '0;
            dbg_cnt_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                refused_cnt_reg <= refused_cnt_next;
                cr3_cnt_reg     <= cr3_cnt_next;
                dbg_cnt_reg     <= dbg_cnt_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= req.kind;
            s1_q_reg    <= req.exit_qualification;
            s1_val_reg  <= req.gpr_value;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // result beat
    assign rsp.valid              = out_valid_reg;
    assign rsp.handled            = out_reg.handled;
    assign rsp.pin_refused        = out_reg.pin_refused;
    assign rsp.gpr_write          = out_reg.gpr_write;
    assign rsp.gpr_index          = out_reg.gpr_index;
    assign rsp.gpr_data           = out_reg.gpr_data;
    assign rsp.installed_value    = out_reg.installed_value;
    assign rsp.shadow_value       = out_reg.shadow_value;
    assign rsp.refused_total      = out_reg.refused_total;
    assign rsp.cr3_switch_total   = out_reg.cr3_switch_total;
    assign rsp.debug_access_total = out_reg.debug_access_total;

endmodule

`default_nettype wire
